FILE: sv/mp2d_pkg.sv
// Shared definitions for the 2-D max pooling engine: register indexes, sizes,
// and the microcode store that sequences one fetch through the datapath.
// Depends on nothing; used by max_pool_2d_engine.
package mp2d_pkg;

  // Default sizes handed to the top level.
  localparam int FRAME_WORDS_DEF = 65536;
  localparam int MAX_KERNEL_DEF  = 8;

  // Channel count saturates here, and its register is this wide.
  localparam int          CHAN_W     = 11;
  localparam logic [10:0] CHAN_LIMIT = 11'd1024;

  localparam int DIM_W    = 9;   // rows, columns and output positions
  localparam int OCHAN_W  = 10;  // output channel position
  localparam int KCFG_W   = 4;   // kernel and stride registers
  localparam int PROD_W   = 13;  // position times stride
  localparam int SPAN_W   = 14;  // window row or column being read
  localparam int LIM_W    = 10;  // last legal window origin
  localparam int PITCH_W  = 20;  // columns times channels
  localparam int BASE_W   = 23;  // row origin times columns plus column origin
  localparam int ADDR_CALC_W = 35;  // full sample address before range check
  localparam int SAMPLE_W = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam logic [2:0] REG_IN_ROWS     = 3'd0;
  localparam logic [2:0] REG_IN_COLS     = 3'd1;
  localparam logic [2:0] REG_CHANNELS    = 3'd2;
  localparam logic [2:0] REG_KERNEL_ROWS = 3'd3;
  localparam logic [2:0] REG_KERNEL_COLS = 3'd4;
  localparam logic [2:0] REG_STRIDE_ROWS = 3'd5;
  localparam logic [2:0] REG_STRIDE_COLS = 3'd6;
  localparam logic [2:0] REG_ROUND_UP    = 3'd7;

  // Item kinds and result status codes.
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_FETCH   = 1'b1;
  localparam logic STATUS_VALID = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Microcode addresses.
  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_MUL   = 3'd1;
  localparam step_t STEP_CHECK = 3'd2;
  localparam step_t STEP_BASE  = 3'd3;
  localparam step_t STEP_SCAN  = 3'd4;
  localparam step_t STEP_DRAIN = 3'd5;
  localparam step_t STEP_EMIT  = 3'd6;
  localparam step_t STEP_NORES = 3'd7;

  typedef enum logic [2:0] {
    OP_IDLE,   // take loads and fetches
    OP_MUL,    // position products and row pitch
    OP_CHECK,  // range check, window origin in samples
    OP_BASE,   // window origin address, scan set-up
    OP_SCAN,   // one memory read per cycle over the window
    OP_DRAIN,  // fold in the last read
    OP_EMIT,   // give the maximum, step the output position
    OP_NORES   // give the empty answer
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_FETCH,
    COND_FAIL,
    COND_MORE
  } cond_t;

  // A taken jump goes to target, otherwise the step counter advances by one.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    case (s)
      STEP_IDLE:  w = '{op: OP_IDLE,  cond: COND_NO_FETCH, target: STEP_IDLE};
      STEP_MUL:   w = '{op: OP_MUL,   cond: COND_NEVER,    target: STEP_IDLE};
      STEP_CHECK: w = '{op: OP_CHECK, cond: COND_FAIL,     target: STEP_NORES};
      STEP_BASE:  w = '{op: OP_BASE,  cond: COND_NEVER,    target: STEP_IDLE};
      STEP_SCAN:  w = '{op: OP_SCAN,  cond: COND_MORE,     target: STEP_SCAN};
      STEP_DRAIN: w = '{op: OP_DRAIN, cond: COND_NEVER,    target: STEP_IDLE};
      STEP_EMIT:  w = '{op: OP_EMIT,  cond: COND_ALWAYS,   target: STEP_IDLE};
      STEP_NORES: w = '{op: OP_NORES, cond: COND_ALWAYS,   target: STEP_IDLE};
      default:    w = '{op: OP_IDLE,  cond: COND_ALWAYS,   target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: sv/mp2d_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the sample store of the pooling engine.
module mp2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/max_pool_2d_engine.sv
// 2-D max pooling engine: sample store, configuration registers and a
// microcoded sequencer that walks each pooling window through the store.
// Depends on mp2d_pkg and mp2d_ram.
//
//   Channel   Beat marked by             Carries
//   -------   ------------------------   ------------------------------------
//   command   start high, busy low       kind, frame_start, sample
//   result    result_strobe, one cycle   pooled_value, last_result, status
//   config    cfg_valid and cfg_ready    cfg_index, cfg_data
//
// Busy never rises for a load.
// A fetch keeps busy high through the multiply, check, base, scan, drain and
// emit steps: the scan reads one stored sample per cycle through the single
// read port of the store. A fetch with no result left goes from the check
// step to the empty answer. The result beat is in the first cycle in which
// busy is low again. Reset is synchronous and leaves the store contents
// undefined. The receiver cannot stall; cfg_ready is always high.
module max_pool_2d_engine #(
  parameter int FRAME_WORDS = mp2d_pkg::FRAME_WORDS_DEF,
  parameter int MAX_KERNEL  = mp2d_pkg::MAX_KERNEL_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 kind,
  input  logic                                 frame_start,
  input  logic signed [mp2d_pkg::SAMPLE_W-1:0] sample,
  output logic                                 result_strobe,
  output logic signed [mp2d_pkg::SAMPLE_W-1:0] pooled_value,
  output logic                                 last_result,
  output logic                                 status,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW  = $clog2(FRAME_WORDS);
  localparam int LCW = $clog2(FRAME_WORDS + 1);
  localparam int KW  = $clog2(MAX_KERNEL + 1);

  localparam int DW = mp2d_pkg::DIM_W;
  localparam int SW = mp2d_pkg::SPAN_W;
  localparam int XW = mp2d_pkg::ADDR_CALC_W;

  // Configuration registers.
  logic [DW-1:0]                 in_rows, in_cols;
  logic [mp2d_pkg::CHAN_W-1:0]   channels;
  logic [mp2d_pkg::KCFG_W-1:0]   kernel_rows, kernel_cols, stride_rows, stride_cols;
  logic                          round_up;

  // Frame counters.
  logic [LCW-1:0]                load_count;
  logic [DW-1:0]                 out_row_pos, out_col_pos;
  logic [mp2d_pkg::OCHAN_W-1:0]  out_chan_pos;
  logic                          fetch_done;

  // Sequencer.
  mp2d_pkg::step_t step, step_next;
  mp2d_pkg::ctrl_t ctrl;
  logic            jump;

  // Datapath registers.
  logic [mp2d_pkg::PROD_W-1:0]   prod_r, prod_c;
  logic [mp2d_pkg::PITCH_W-1:0]  pitch;
  logic                          geo_bad;
  logic                          row_last, col_last, chan_last;
  logic [mp2d_pkg::BASE_W-1:0]   base1;
  logic [XW-1:0]                 cur_addr, row_addr;
  logic [SW-1:0]                 rd_row, rd_col;
  logic [KW-1:0]                 ki, kj;
  logic                          pend_valid, pend_mem, first;
  logic signed [mp2d_pkg::SAMPLE_W-1:0] best;

  // Combinational terms.
  logic                          accept, fetch_go;
  logic [mp2d_pkg::CHAN_W-1:0]   ch_eff;
  logic [KW-1:0]                 kr_eff, kc_eff;
  logic                          bad_now;
  logic [mp2d_pkg::LIM_W-1:0]    lim_r, lim_c;
  logic                          row_in, col_in, chan_in;
  logic                          row_end, col_end, chan_end;
  logic                          fail, more, kj_end, rd_ok;
  logic [LCW-1:0]                ld_idx;
  logic                          ram_we;
  logic [mp2d_pkg::SAMPLE_W-1:0] rdata;
  logic signed [mp2d_pkg::SAMPLE_W-1:0] fold_v;

  assign busy      = (step != mp2d_pkg::STEP_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign fetch_go  = accept && (kind == mp2d_pkg::KIND_FETCH);

  // Saturated geometry.
  always_comb begin
    ch_eff = (channels > mp2d_pkg::CHAN_LIMIT) ? mp2d_pkg::CHAN_LIMIT : channels;
    kr_eff = ({1'b0, kernel_rows} > 5'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : KW'(kernel_rows);
    kc_eff = ({1'b0, kernel_cols} > 5'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : KW'(kernel_cols);
    bad_now = (in_rows == '0) || (in_cols == '0) || (ch_eff == '0) ||
              (kr_eff == '0) || (kc_eff == '0) ||
              (stride_rows == '0) || (stride_cols == '0) ||
              (DW'(kr_eff) > in_rows) || (DW'(kc_eff) > in_cols);
  end

  // A window origin is legal while position * stride stays at or below
  // input - kernel, or one stride beyond that in ceil mode. The last legal
  // position is the one whose successor is not.
  always_comb begin
    lim_r = mp2d_pkg::LIM_W'(in_rows - DW'(kr_eff)) +
            (round_up ? mp2d_pkg::LIM_W'(stride_rows) : '0);
    lim_c = mp2d_pkg::LIM_W'(in_cols - DW'(kc_eff)) +
            (round_up ? mp2d_pkg::LIM_W'(stride_cols) : '0);
    row_in  = SW'(prod_r) <= SW'(lim_r);
    col_in  = SW'(prod_c) <= SW'(lim_c);
    row_end = row_in && !((SW'(prod_r) + SW'(stride_rows)) <= SW'(lim_r));
    col_end = col_in && !((SW'(prod_c) + SW'(stride_cols)) <= SW'(lim_c));
    chan_in  = mp2d_pkg::CHAN_W'(out_chan_pos) < ch_eff;
    chan_end = mp2d_pkg::CHAN_W'(out_chan_pos) == (ch_eff - 11'd1);
    fail = geo_bad || fetch_done || !row_in || !col_in || !chan_in;
  end

  always_comb begin
    kj_end = (kj == (kc_eff - KW'(1)));
    more   = !(kj_end && (ki == (kr_eff - KW'(1))));
    rd_ok  = (rd_row < SW'(in_rows)) && (rd_col < SW'(in_cols)) &&
             (cur_addr < XW'(FRAME_WORDS));
  end

  // Loads write at the next free word; frame_start restarts at word zero.
  always_comb begin
    ld_idx = frame_start ? '0 : load_count;
    ram_we = accept && (kind == mp2d_pkg::KIND_LOAD) && (ld_idx < LCW'(FRAME_WORDS));
  end

  // Sequencer.
  always_comb begin
    ctrl = mp2d_pkg::ucode(step);
    case (ctrl.cond)
      mp2d_pkg::COND_NEVER:    jump = 1'b0;
      mp2d_pkg::COND_ALWAYS:   jump = 1'b1;
      mp2d_pkg::COND_NO_FETCH: jump = !fetch_go;
      mp2d_pkg::COND_FAIL:     jump = fail;
      mp2d_pkg::COND_MORE:     jump = more;
      default:                 jump = 1'b1;
    endcase
    step_next = jump ? ctrl.target : step + 3'd1;
  end

  // Sample from the read issued in the previous cycle; positions outside
  // the map read as zero.
  assign fold_v = pend_mem ? $signed(rdata) : '0;

  mp2d_ram #(
    .WIDTH (mp2d_pkg::SAMPLE_W),
    .DEPTH (FRAME_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ld_idx[AW-1:0]),
    .wdata (sample),
    .raddr (cur_addr[AW-1:0]),
    .rdata (rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_rows     <= DW'(1);
      in_cols     <= DW'(1);
      channels    <= mp2d_pkg::CHAN_W'(1);
      kernel_rows <= 4'd2;
      kernel_cols <= 4'd2;
      stride_rows <= 4'd2;
      stride_cols <= 4'd2;
      round_up    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mp2d_pkg::REG_IN_ROWS:     in_rows     <= cfg_data[DW-1:0];
        mp2d_pkg::REG_IN_COLS:     in_cols     <= cfg_data[DW-1:0];
        mp2d_pkg::REG_CHANNELS:    channels    <= cfg_data;
        mp2d_pkg::REG_KERNEL_ROWS: kernel_rows <= cfg_data[3:0];
        mp2d_pkg::REG_KERNEL_COLS: kernel_cols <= cfg_data[3:0];
        mp2d_pkg::REG_STRIDE_ROWS: stride_rows <= cfg_data[3:0];
        mp2d_pkg::REG_STRIDE_COLS: stride_cols <= cfg_data[3:0];
        mp2d_pkg::REG_ROUND_UP:    round_up    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Control state and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= mp2d_pkg::STEP_IDLE;
      load_count    <= '0;
      out_row_pos   <= '0;
      out_col_pos   <= '0;
      out_chan_pos  <= '0;
      fetch_done    <= 1'b0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      step          <= step_next;
      result_strobe <= (ctrl.op == mp2d_pkg::OP_EMIT) || (ctrl.op == mp2d_pkg::OP_NORES);

      // Fold the returning sample into the running maximum.
      if (pend_valid) begin
        if (first || (fold_v > best)) begin
          best <= fold_v;
        end
        first <= 1'b0;
      end

      case (ctrl.op)
        mp2d_pkg::OP_IDLE: begin
          if (accept) begin
            if (frame_start) begin
              out_row_pos  <= '0;
              out_col_pos  <= '0;
              out_chan_pos <= '0;
              fetch_done   <= 1'b0;
            end
            if (ram_we) begin
              load_count <= ld_idx + LCW'(1);
            end else if (frame_start) begin
              load_count <= '0;
            end
          end
        end
        mp2d_pkg::OP_MUL: begin
          prod_r  <= mp2d_pkg::PROD_W'(out_row_pos) * mp2d_pkg::PROD_W'(stride_rows);
          prod_c  <= mp2d_pkg::PROD_W'(out_col_pos) * mp2d_pkg::PROD_W'(stride_cols);
          pitch   <= mp2d_pkg::PITCH_W'(in_cols) * mp2d_pkg::PITCH_W'(ch_eff);
          geo_bad <= bad_now;
        end
        mp2d_pkg::OP_CHECK: begin
          row_last  <= row_end;
          col_last  <= col_end;
          chan_last <= chan_end;
          base1     <= mp2d_pkg::BASE_W'(prod_r) * mp2d_pkg::BASE_W'(in_cols) +
                       mp2d_pkg::BASE_W'(prod_c);
        end
        mp2d_pkg::OP_BASE: begin
          cur_addr   <= XW'(base1) * XW'(ch_eff) + XW'(out_chan_pos);
          row_addr   <= XW'(base1) * XW'(ch_eff) + XW'(out_chan_pos);
          rd_row     <= SW'(prod_r);
          rd_col     <= SW'(prod_c);
          ki         <= '0;
          kj         <= '0;
          first      <= 1'b1;
          pend_valid <= 1'b0;
        end
        mp2d_pkg::OP_SCAN: begin
          pend_valid <= 1'b1;
          pend_mem   <= rd_ok;
          if (kj_end) begin
            // Next window row: back to the left edge, one row pitch down.
            kj       <= '0;
            ki       <= ki + KW'(1);
            rd_row   <= rd_row + SW'(1);
            rd_col   <= SW'(prod_c);
            row_addr <= row_addr + XW'(pitch);
            cur_addr <= row_addr + XW'(pitch);
          end else begin
            kj       <= kj + KW'(1);
            rd_col   <= rd_col + SW'(1);
            cur_addr <= cur_addr + XW'(ch_eff);
          end
        end
        mp2d_pkg::OP_DRAIN: begin
          pend_valid <= 1'b0;
        end
        mp2d_pkg::OP_EMIT: begin
          pooled_value  <= best;
          last_result   <= row_last && col_last && chan_last;
          status        <= mp2d_pkg::STATUS_VALID;
          if (chan_last) begin
            out_chan_pos <= '0;
            if (col_last) begin
              out_col_pos <= '0;
              if (row_last) begin
                out_row_pos <= '0;
                fetch_done  <= 1'b1;
              end else begin
                out_row_pos <= out_row_pos + DW'(1);
              end
            end else begin
              out_col_pos <= out_col_pos + DW'(1);
            end
          end else begin
            out_chan_pos <= out_chan_pos + mp2d_pkg::OCHAN_W'(1);
          end
        end
        mp2d_pkg::OP_NORES: begin
          pooled_value  <= '0;
          last_result   <= 1'b0;
          status        <= mp2d_pkg::STATUS_EMPTY;
        end
        default: ;
      endcase
    end
  end

  // An empty answer carries a zero value and is never the last result.
  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && (status == mp2d_pkg::STATUS_EMPTY)) |->
      ((pooled_value == '0) && !last_result))
    else $error("empty result carries a value or a last mark");

  // A load never holds the command channel off.
  a_load_single_cycle: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == mp2d_pkg::KIND_LOAD)) |=> !busy)
    else $error("busy raised after a load");

  // Every result beat ends a stretch of work.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result beat without a fetch in progress");

  // The last read of a window is still in flight when the scan ends.
  a_drain_has_read: assert property (@(posedge clk) disable iff (rst)
    (step == mp2d_pkg::STEP_DRAIN) |-> pend_valid)
    else $error("drain step without an outstanding read");

  // The load counter stops at the store size.
  a_load_count_bound: assert property (@(posedge clk) disable iff (rst)
    load_count <= LCW'(FRAME_WORDS))
    else $error("load counter beyond the store");

endmodule
